/* design/cjtg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjtg_pkg: shared types and constants
// Opcodes, status codes, controller-to-datapath commands, lookup tables.
// ----------------------------------------------------------------------------
package cjtg_pkg;

	localparam int POS_BITS         = 32;
	localparam int SQ_STEPS         = 30;  // result bits of the 60-bit square root
	localparam int CORDIC_STEPS_DEF = 24;
	localparam int MUL_SEQ_LEN      = 13;

	// input opcodes
	localparam logic [1:0] OPC_START = 2'd0;
	localparam logic [1:0] OPC_TICK  = 2'd1;
	localparam logic [1:0] OPC_STOP  = 2'd2;

	// run status
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RUN  = 3'd1;
	localparam logic [2:0] ST_OK   = 3'd2;
	localparam logic [2:0] ST_INTR = 3'd3;
	localparam logic [2:0] ST_FAIL = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_JOINT_MIN   = 3'd0;
	localparam logic [2:0] REG_JOINT_MAX   = 3'd1;
	localparam logic [2:0] REG_LOWER       = 3'd2;
	localparam logic [2:0] REG_UPPER       = 3'd3;
	localparam logic [2:0] REG_PHASE_STEP  = 3'd4;
	localparam logic [2:0] REG_ANG_RATE    = 3'd5;
	localparam logic [2:0] REG_DURATION    = 3'd6;

	// datapath operations
	localparam logic [3:0] DP_NOP      = 4'd0;
	localparam logic [3:0] DP_LOAD     = 4'd1;
	localparam logic [3:0] DP_CLAMP    = 4'd2;
	localparam logic [3:0] DP_COMMIT   = 4'd3;
	localparam logic [3:0] DP_SQ_STEP  = 4'd4;
	localparam logic [3:0] DP_SQB_INIT = 4'd5;
	localparam logic [3:0] DP_VEC_INIT = 4'd6;
	localparam logic [3:0] DP_VEC_STEP = 4'd7;
	localparam logic [3:0] DP_VEC_DONE = 4'd8;
	localparam logic [3:0] DP_PH       = 4'd9;
	localparam logic [3:0] DP_ROT_INIT = 4'd10;
	localparam logic [3:0] DP_ROT_STEP = 4'd11;
	localparam logic [3:0] DP_ROT_DONE = 4'd12;
	localparam logic [3:0] DP_MLO      = 4'd13;
	localparam logic [3:0] DP_MHI      = 4'd14;
	localparam logic [3:0] DP_CAPT     = 4'd15;

	// multiplier operand / capture select
	localparam logic [2:0] MS_POS = 3'd0;
	localparam logic [2:0] MS_P   = 3'd1;
	localparam logic [2:0] MS_V   = 3'd2;
	localparam logic [2:0] MS_Q   = 3'd3;
	localparam logic [2:0] MS_A   = 3'd4;

	// elapsed counter updates
	localparam logic [2:0] EL_HOLD  = 3'd0;
	localparam logic [2:0] EL_CLR   = 3'd1;
	localparam logic [2:0] EL_INC   = 3'd2;
	localparam logic [2:0] EL_SETD  = 3'd3;
	localparam logic [2:0] EL_SETD1 = 3'd4;

	// result publishing
	localparam logic [1:0] PUB_NONE = 2'd0;
	localparam logic [1:0] PUB_TRAJ = 2'd1;
	localparam logic [1:0] PUB_ZERO = 2'd2;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] msel;
	} cjtg_mop_t;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] msel;
		logic [4:0] step;
		logic [2:0] el;
		logic [1:0] pub;
	} cjtg_cmd_t;

	typedef struct packed {
		logic fail;      // clamped bounds or start position rejected
		logic past_end;  // elapsed count beyond duration
	} cjtg_stat_t;

	// multiply / capture sequence of one trajectory evaluation
	function automatic cjtg_mop_t mul_seq(input logic [3:0] idx);
		cjtg_mop_t m;
		unique case (idx)
			4'd0:    m = '{DP_MLO,  MS_POS};
			4'd1:    m = '{DP_CAPT, MS_POS};
			4'd2:    m = '{DP_MLO,  MS_P};
			4'd3:    m = '{DP_CAPT, MS_P};
			4'd4:    m = '{DP_MLO,  MS_V};
			4'd5:    m = '{DP_MHI,  MS_V};
			4'd6:    m = '{DP_CAPT, MS_V};
			4'd7:    m = '{DP_MLO,  MS_Q};
			4'd8:    m = '{DP_MHI,  MS_Q};
			4'd9:    m = '{DP_CAPT, MS_Q};
			4'd10:   m = '{DP_MLO,  MS_A};
			4'd11:   m = '{DP_MHI,  MS_A};
			4'd12:   m = '{DP_CAPT, MS_A};
			default: m = '{DP_NOP,  MS_POS};
		endcase
		return m;
	endfunction

	// atan(2^-i) in turns * 2^32
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:  a = 32'h20000000; 5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B; 5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43; 5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E; 5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53; 5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98; 5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6; 5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA; 5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE; 5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30; 5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C; 5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3; 5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029; 5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A; 5'd27: a = 32'h00000005;
			5'd28: a = 32'h00000003; 5'd29: a = 32'h00000001;
			5'd30: a = 32'h00000001; 5'd31: a = 32'h00000000;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

/* design/cjtg_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjtg_datapath: arithmetic of the trajectory generator
// Config registers, clamp, shared square root, shared CORDIC, one 32x32
// multiplier with a 96-bit accumulator, result registers.
// ----------------------------------------------------------------------------
module cjtg_datapath
	import cjtg_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [31:0]                cfg_data,
	input  logic signed [POS_BITS-1:0] start_position,
	input  cjtg_cmd_t                  cmd,
	output cjtg_stat_t                 stat,
	output logic signed [31:0]         position_target,
	output logic signed [31:0]         velocity,
	output logic signed [31:0]         acceleration,
	output logic [24:0]                progress_ticks
);

	localparam logic signed [33:0] ONE30 = 34'sd1073741824;
	localparam logic signed [33:0] ONE31 = 34'sd2147483648;
	localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

	logic signed [31:0] jmin_q, jmax_q, lb_q, ub_q;
	logic [31:0] pstep_q, rate_q;
	logic [23:0] dur_q;

	logic signed [31:0] st_q, lo_t_q, hi_t_q, lo_q, hi_q;
	logic [24:0] elapsed_q;
	logic [31:0] start_phase_q, ph_q;

	logic [59:0] rad_q;
	logic [32:0] rem_q;
	logic [29:0] root_q;

	logic signed [33:0] vx_q, vy_q, vz_q;
	logic flip_q;

	logic signed [31:0] c_q, s_q;
	logic [31:0] d_q;
	logic [95:0] acc_q;
	logic [63:0] p_q, q_q;
	logic signed [31:0] pos_q, vel_q, accel_q;

	// clamp
	logic signed [31:0] lo_a, lo_c, hi_a, hi_c;
	assign lo_a = (lb_q < jmin_q) ? jmin_q : lb_q;
	assign lo_c = (lo_a > jmax_q) ? jmax_q : lo_a;
	assign hi_a = (ub_q < jmin_q) ? jmin_q : ub_q;
	assign hi_c = (hi_a > jmax_q) ? jmax_q : hi_a;

	assign stat.fail     = (lo_t_q >= hi_t_q) || (st_q < lo_t_q) || (st_q > hi_t_q);
	assign stat.past_end = elapsed_q > {1'b0, dur_q};

	// square root step
	logic [34:0] sq_trial, sq_sub, sq_diff;
	logic sq_ge;
	assign sq_trial = {rem_q, rad_q[59:58]};
	assign sq_sub   = {3'b000, root_q, 2'b01};
	assign sq_diff  = sq_trial - sq_sub;
	assign sq_ge    = sq_trial >= sq_sub;

	logic [31:0] diff_lo, diff_hi;
	assign diff_lo = 32'(st_q - lo_t_q);
	assign diff_hi = 32'(hi_q - st_q);

	// CORDIC shared by vectoring and rotation
	logic signed [33:0] x_sh, y_sh, atan_v;
	assign x_sh   = vx_q >>> cmd.step;
	assign y_sh   = vy_q >>> cmd.step;
	assign atan_v = signed'({2'b00, atan_turn(cmd.step)});

	logic signed [33:0] zs, zc;
	assign zs = {{2{ph_q[31]}}, ph_q};
	assign zc = (vz_q < 0) ? 34'sd0 : ((vz_q > ONE30) ? ONE30 : vz_q);

	logic signed [33:0] xf, yf, xcl, ycl;
	assign xf  = flip_q ? -vx_q : vx_q;
	assign yf  = flip_q ? -vy_q : vy_q;
	assign xcl = (xf > ONE30) ? ONE30 : ((xf < -ONE30) ? -ONE30 : xf);
	assign ycl = (yf > ONE30) ? ONE30 : ((yf < -ONE30) ? -ONE30 : yf);

	// phase at the current count
	logic [56:0] ph_prod;
	assign ph_prod = elapsed_q * pstep_q;

	// multiplier operands
	logic [31:0] csum, abs_c, abs_s;
	logic [30:0] h_v;
	assign csum  = 32'(c_q + 32'sd1073741824);
	assign h_v   = csum[31:1];
	assign abs_c = (c_q < 0) ? 32'(-c_q) : c_q;
	assign abs_s = (s_q < 0) ? 32'(-s_q) : s_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_r;
	always_comb begin
		unique case (cmd.msel)
			MS_POS: begin mul_a = d_q; mul_b = {1'b0, h_v}; end
			MS_P: begin mul_a = d_q; mul_b = rate_q; end
			MS_V: begin
				mul_a = (cmd.op == DP_MHI) ? p_q[63:32] : p_q[31:0];
				mul_b = abs_s;
			end
			MS_Q: begin
				mul_a = (cmd.op == DP_MHI) ? p_q[63:32] : p_q[31:0];
				mul_b = rate_q;
			end
			MS_A: begin
				mul_a = (cmd.op == DP_MHI) ? q_q[63:32] : q_q[31:0];
				mul_b = abs_c;
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign mul_r = mul_a * mul_b;

	logic [33:0] pos_off;
	assign pos_off = ({1'b0, acc_q[61:29]} + 34'd1) >> 1;

	function automatic logic signed [31:0] sat32(input logic [40:0] mag, input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			r = (mag >= 41'h80000000) ? 32'sh80000000 : 32'(-mag);
		end else begin
			r = (mag > 41'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(mag);
		end
		return r;
	endfunction

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jmin_q  <= 32'sh80000000;
			jmax_q  <= 32'sh7FFFFFFF;
			lb_q    <= '0;
			ub_q    <= '0;
			pstep_q <= '0;
			rate_q  <= '0;
			dur_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_JOINT_MIN:  jmin_q  <= cfg_data;
				REG_JOINT_MAX:  jmax_q  <= cfg_data;
				REG_LOWER:      lb_q    <= cfg_data;
				REG_UPPER:      ub_q    <= cfg_data;
				REG_PHASE_STEP: pstep_q <= cfg_data;
				REG_ANG_RATE:   rate_q  <= cfg_data;
				REG_DURATION:   dur_q   <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q     <= '0;
			start_phase_q <= '0;
			lo_q          <= '0;
			hi_q          <= '0;
		end else begin
			unique case (cmd.el)
				EL_CLR:   elapsed_q <= '0;
				EL_INC:   elapsed_q <= elapsed_q + 25'd1;
				EL_SETD:  elapsed_q <= {1'b0, dur_q};
				EL_SETD1: elapsed_q <= {1'b0, dur_q} + 25'd1;
				default: ;
			endcase
			if (cmd.op == DP_COMMIT) begin
				lo_q <= lo_t_q;
				hi_q <= hi_t_q;
			end
			if (cmd.op == DP_VEC_DONE) start_phase_q <= {zc[30:0], 1'b0};
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_LOAD: st_q <= start_position;
			DP_CLAMP: begin lo_t_q <= lo_c; hi_t_q <= hi_c; end
			DP_COMMIT: begin
				rad_q  <= {diff_lo, 28'd0};
				rem_q  <= '0;
				root_q <= '0;
			end
			DP_SQ_STEP: begin
				rem_q  <= sq_ge ? sq_diff[32:0] : sq_trial[32:0];
				root_q <= {root_q[28:0], sq_ge};
				rad_q  <= {rad_q[57:0], 2'b00};
			end
			DP_SQB_INIT: begin
				vx_q   <= {4'd0, root_q};
				rad_q  <= {diff_hi, 28'd0};
				rem_q  <= '0;
				root_q <= '0;
			end
			DP_VEC_INIT: begin vy_q <= {4'd0, root_q}; vz_q <= '0; end
			DP_VEC_STEP: begin
				if (vy_q > 0) begin
					vx_q <= vx_q + y_sh; vy_q <= vy_q - x_sh; vz_q <= vz_q + atan_v;
				end else begin
					vx_q <= vx_q - y_sh; vy_q <= vy_q + x_sh; vz_q <= vz_q - atan_v;
				end
			end
			DP_PH: ph_q <= start_phase_q + ph_prod[31:0];
			DP_ROT_INIT: begin
				vx_q <= CORDIC_GAIN_INV;
				vy_q <= '0;
				if (zs > ONE30) begin
					vz_q <= zs - ONE31; flip_q <= 1'b1;
				end else if (zs < -ONE30) begin
					vz_q <= zs + ONE31; flip_q <= 1'b1;
				end else begin
					vz_q <= zs; flip_q <= 1'b0;
				end
			end
			DP_ROT_STEP: begin
				if (vz_q >= 0) begin
					vx_q <= vx_q - y_sh; vy_q <= vy_q + x_sh; vz_q <= vz_q - atan_v;
				end else begin
					vx_q <= vx_q + y_sh; vy_q <= vy_q - x_sh; vz_q <= vz_q + atan_v;
				end
			end
			DP_ROT_DONE: begin
				c_q <= 32'(xcl);
				s_q <= 32'(ycl);
				d_q <= 32'(hi_q - lo_q);
			end
			DP_MLO: acc_q <= {32'd0, mul_r};
			DP_MHI: acc_q <= acc_q + {mul_r, 32'd0};
			DP_CAPT: begin
				unique case (cmd.msel)
					MS_POS: pos_q   <= lo_q + signed'(pos_off[31:0]);
					MS_P:   p_q     <= acc_q[63:0];
					MS_V:   vel_q   <= sat32({4'd0, acc_q[95:59]}, s_q > 0);
					MS_Q:   q_q     <= acc_q[95:32];
					MS_A:   accel_q <= sat32(acc_q[95:55], c_q > 0);
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// result registers
	always_ff @(posedge clk) begin
		unique case (cmd.pub)
			PUB_TRAJ: begin
				position_target <= pos_q;
				velocity        <= vel_q;
				acceleration    <= accel_q;
				progress_ticks  <= elapsed_q;
			end
			PUB_ZERO: begin
				position_target <= '0;
				velocity        <= '0;
				acceleration    <= '0;
				progress_ticks  <= elapsed_q;
			end
			default: ;
		endcase
	end

endmodule

/* design/cjtg_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjtg_ctrl: sequencing state machine
// Owns run status, stop flag, handshakes and the command stream.
// ----------------------------------------------------------------------------
module cjtg_ctrl
	import cjtg_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic       settled,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] run_status,
	output cjtg_cmd_t  cmd,
	input  cjtg_stat_t stat
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CLAMP    = 4'd1;
	localparam logic [3:0] S_CHECK    = 4'd2;
	localparam logic [3:0] S_SQA      = 4'd3;
	localparam logic [3:0] S_SQB_INIT = 4'd4;
	localparam logic [3:0] S_SQB      = 4'd5;
	localparam logic [3:0] S_VEC_INIT = 4'd6;
	localparam logic [3:0] S_VEC      = 4'd7;
	localparam logic [3:0] S_VEC_DONE = 4'd8;
	localparam logic [3:0] S_PH       = 4'd9;
	localparam logic [3:0] S_ROT_INIT = 4'd10;
	localparam logic [3:0] S_ROT      = 4'd11;
	localparam logic [3:0] S_ROT_DONE = 4'd12;
	localparam logic [3:0] S_MUL      = 4'd13;
	localparam logic [3:0] S_UPD      = 4'd14;
	localparam logic [3:0] S_PUB      = 4'd15;

	localparam logic [4:0] SQ_LAST = 5'(SQ_STEPS - 1);
	localparam logic [4:0] CO_LAST = 5'(CORDIC_STEPS - 1);
	localparam logic [3:0] MS_LAST = 4'(MUL_SEQ_LEN - 1);

	logic [3:0] state_q, state_d;
	logic [4:0] step_q;
	logic [3:0] mseq_q;
	logic [1:0] opc_q;
	logic       settled_q, stop_q, traj_q, out_valid_q;
	logic [2:0] status_q, status_d, rstat_q;
	logic       accept, step_last, pub_go;
	cjtg_mop_t  mop;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign run_status = rstat_q;
	assign mop        = mul_seq(mseq_q);
	assign pub_go     = !out_valid_q || out_ready;

	always_comb begin
		state_d   = state_q;
		status_d  = status_q;
		step_last = 1'b0;
		cmd       = '0;
		cmd.step  = step_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority case (opcode)
						OPC_START: begin cmd.op = DP_LOAD; state_d = S_CLAMP; end
						OPC_TICK:  state_d = (status_q == ST_RUN) ? S_PH : S_PUB;
						default:   state_d = S_PUB;
					endcase
				end
			end
			S_CLAMP: begin cmd.op = DP_CLAMP; state_d = S_CHECK; end
			S_CHECK: begin
				cmd.el = EL_CLR;
				if (stat.fail) begin
					status_d = ST_FAIL;
					state_d  = S_PUB;
				end else begin
					cmd.op  = DP_COMMIT;
					state_d = S_SQA;
				end
			end
			S_SQA: begin
				cmd.op    = DP_SQ_STEP;
				step_last = (step_q == SQ_LAST);
				if (step_last) state_d = S_SQB_INIT;
			end
			S_SQB_INIT: begin cmd.op = DP_SQB_INIT; state_d = S_SQB; end
			S_SQB: begin
				cmd.op    = DP_SQ_STEP;
				step_last = (step_q == SQ_LAST);
				if (step_last) state_d = S_VEC_INIT;
			end
			S_VEC_INIT: begin cmd.op = DP_VEC_INIT; state_d = S_VEC; end
			S_VEC: begin
				cmd.op    = DP_VEC_STEP;
				step_last = (step_q == CO_LAST);
				if (step_last) state_d = S_VEC_DONE;
			end
			S_VEC_DONE: begin
				cmd.op   = DP_VEC_DONE;
				status_d = ST_RUN;
				state_d  = S_PH;
			end
			S_PH: begin cmd.op = DP_PH; state_d = S_ROT_INIT; end
			S_ROT_INIT: begin cmd.op = DP_ROT_INIT; state_d = S_ROT; end
			S_ROT: begin
				cmd.op    = DP_ROT_STEP;
				step_last = (step_q == CO_LAST);
				if (step_last) state_d = S_ROT_DONE;
			end
			S_ROT_DONE: begin cmd.op = DP_ROT_DONE; state_d = S_MUL; end
			S_MUL: begin
				cmd.op   = mop.op;
				cmd.msel = mop.msel;
				if (mseq_q == MS_LAST) state_d = (opc_q == OPC_START) ? S_PUB : S_UPD;
			end
			S_UPD: begin
				// count clamps at the duration; stop only counts before that
				if (stat.past_end) begin
					cmd.el = settled_q ? EL_SETD : EL_SETD1;
					if (settled_q) status_d = ST_OK;
				end else if (stop_q) begin
					status_d = ST_INTR;
				end else begin
					cmd.el = EL_INC;
				end
				state_d = S_PUB;
			end
			S_PUB: begin
				if (pub_go) begin
					cmd.pub = traj_q ? PUB_TRAJ : PUB_ZERO;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			mseq_q      <= '0;
			opc_q       <= OPC_START;
			settled_q   <= 1'b0;
			stop_q      <= 1'b0;
			traj_q      <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_IDLE;
			rstat_q     <= ST_IDLE;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (accept) begin
				opc_q     <= opcode;
				settled_q <= settled;
				traj_q    <= (opcode == OPC_TICK) && (status_q == ST_RUN);
				if (opcode == OPC_START) stop_q <= 1'b0;
				else if (opcode == OPC_STOP && status_q == ST_RUN) stop_q <= 1'b1;
			end
			if (state_q == S_VEC_DONE) traj_q <= 1'b1;
			if (state_q == S_SQA || state_q == S_SQB || state_q == S_VEC || state_q == S_ROT)
				step_q <= step_last ? 5'd0 : step_q + 5'd1;
			else
				step_q <= '0;
			if (state_q == S_MUL) mseq_q <= mseq_q + 4'd1;
			else mseq_q <= '0;
			if (state_q == S_PUB && pub_go) begin
				out_valid_q <= 1'b1;
				rstat_q     <= status_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted transaction did not start processing");

	a_vec_sets_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_VEC_DONE |=> status_q == ST_RUN)
		else $error("start phase computed without entering run");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		status_q <= ST_FAIL)
		else $error("status register out of range");

	a_pub_raises_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUB && pub_go) |=> out_valid_q && state_q == S_IDLE)
		else $error("publish did not present a result");

endmodule

/* design/cosine_joint_trajectory_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_joint_trajectory_generator: raised-cosine trajectory for one joint
// Throughput: one transaction at a time; cost set by the shared square root
//   (one bit per cycle) and the shared CORDIC unit (one step per cycle).
// Reset: asynchronous, clears status to idle and config to defaults.
// ----------------------------------------------------------------------------
module cosine_joint_trajectory_generator
	import cjtg_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input transactions
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] start_position,
	input  logic               settled,
	// result transactions
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] position_target,
	output logic signed [31:0] velocity,
	output logic signed [31:0] acceleration,
	output logic [2:0]         run_status,
	output logic [24:0]        progress_ticks,
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	cjtg_cmd_t  cmd;
	cjtg_stat_t stat;

	// config is always accepted; the user must write only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	// controller: status, stop flag, handshakes, step counters
	cjtg_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.settled    (settled),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.run_status (run_status),
		.cmd        (cmd),
		.stat       (stat)
	);

	// datapath: clamp, sqrt, CORDIC, multiply-accumulate, result registers
	cjtg_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.start_position  (start_position),
		.cmd             (cmd),
		.stat            (stat),
		.position_target (position_target),
		.velocity        (velocity),
		.acceleration    (acceleration),
		.progress_ticks  (progress_ticks)
	);

endmodule

/* tb/sv/cosine_joint_trajectory_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_joint_trajectory_generator_tb: self-checking bench for the generator
// Drives start, tick and stop transactions under random handshake pressure,
// predicts every result with a bit-exact fixed-point trajectory model kept in
// the bench, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module cosine_joint_trajectory_generator_tb;
	import cjtg_pkg::*;

	localparam logic [1:0] OPC_UNUSED = 2'd3;   // not decoded, reported like a no-op stop
	localparam int         ROT_STEPS  = CORDIC_STEPS_DEF;
	localparam longint     ONE_Q30    = 64'sd1 << 30;
	localparam longint     CORDIC_K   = 64'sd652032874;  // 1/gain in Q2.30

	// atan(2^-i) in turns * 2^32
	localparam bit [31:0] ARCTAN_LUT [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000};

	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] pos;
		logic               settled;
	} joint_cmd_t;

	typedef struct {
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] acc;
		logic [2:0]         status;
		logic [24:0]        ticks;
	} traj_point_t;

	// DUT signals, all inputs known from time zero
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         opcode = OPC_TICK;
	logic signed [31:0] start_position = '0;
	logic               settled = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] position_target;
	logic signed [31:0] velocity;
	logic signed [31:0] acceleration;
	logic [2:0]         run_status;
	logic [24:0]        progress_ticks;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = REG_JOINT_MIN;
	logic [31:0]        cfg_data = '0;

	cosine_joint_trajectory_generator dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// trajectory model state (mirror of the block's registers)
	// ------------------------------------------------------------------------
	bit [31:0]   shadow_reg [7];
	bit [63:0]   model_elapsed;
	bit [63:0]   model_phase0;
	longint      model_lo, model_hi;
	logic [2:0]  model_status;
	bit          model_stop;

	joint_cmd_t  cmd_queue [$];      // transactions waiting for the driver
	traj_point_t expected_points [$];
	int          error_count = 0;
	int          issued = 0;
	bit          calm = 1'b0;        // no idling in the closing stretch

	function automatic longint sext32(bit [31:0] v);
		return longint'($signed(v));
	endfunction

	// floor(a*b / 2^sh), saturating at 2^64-1
	function automatic bit [63:0] mul_floor(bit [63:0] a, bit [31:0] b, int sh);
		bit [127:0] pr;
		pr = {64'b0, a} * {96'b0, b};
		pr = pr >> sh;
		return (pr[127:64] != 0) ? '1 : pr[63:0];
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// CORDIC vectoring angle in turns*2^32, clamped to a quarter turn
	function automatic longint vec_angle(longint x, longint y);
		longint z, nx, ny;
		z = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(ARCTAN_LUT[i]);
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(ARCTAN_LUT[i]);
			end
			x = nx; y = ny;
		end
		if (z < 0) z = 0;
		if (z > ONE_Q30) z = ONE_Q30;
		return z;
	endfunction

	function automatic bit [31:0] sat_signed(bit [63:0] mag, bit neg);
		if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(mag));
		return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
	endfunction

	// position, velocity and acceleration at the current elapsed count
	function automatic traj_point_t traj_eval();
		traj_point_t t;
		longint      z, c, s, nx, ny;
		bit [63:0]   span, h, off, p, q;
		bit [31:0]   ph;
		bit          flip;
		span = 64'(model_hi - model_lo);
		ph = 32'(model_phase0 + model_elapsed * 64'(shadow_reg[REG_PHASE_STEP]));
		z = sext32(ph);
		c = CORDIC_K;
		s = 0;
		flip = 0;
		// fold into +-quarter turn, rotate back by a half turn afterwards
		if (z > ONE_Q30) begin z -= 2 * ONE_Q30; flip = 1; end
		else if (z < -ONE_Q30) begin z += 2 * ONE_Q30; flip = 1; end
		for (int i = 0; i < ROT_STEPS; i++) begin
			if (z >= 0) begin
				nx = c - (s >>> i); ny = s + (c >>> i); z -= longint'(ARCTAN_LUT[i]);
			end else begin
				nx = c + (s >>> i); ny = s - (c >>> i); z += longint'(ARCTAN_LUT[i]);
			end
			c = nx; s = ny;
		end
		if (flip) begin c = -c; s = -s; end
		if (c > ONE_Q30) c = ONE_Q30;
		if (c < -ONE_Q30) c = -ONE_Q30;
		if (s > ONE_Q30) s = ONE_Q30;
		if (s < -ONE_Q30) s = -ONE_Q30;
		h = 64'(ONE_Q30 + c) >> 1;
		off = (mul_floor(span, h[31:0], 29) + 1) >> 1;
		t.pos = 32'(model_lo + longint'(off));
		p = mul_floor(span, shadow_reg[REG_ANG_RATE], 0);
		t.vel = sat_signed(mul_floor(p, 32'(s < 0 ? -s : s), 59), s > 0);
		q = mul_floor(p, shadow_reg[REG_ANG_RATE], 32);
		t.acc = sat_signed(mul_floor(q, 32'(c < 0 ? -c : c), 55), c > 0);
		return t;
	endfunction

	// requested bounds after clamping to the joint limits
	function automatic void clamped_bounds(output longint lo, output longint hi);
		longint jmin, jmax;
		jmin = sext32(shadow_reg[REG_JOINT_MIN]);
		jmax = sext32(shadow_reg[REG_JOINT_MAX]);
		lo = sext32(shadow_reg[REG_LOWER]);
		hi = sext32(shadow_reg[REG_UPPER]);
		if (lo < jmin) lo = jmin;
		if (lo > jmax) lo = jmax;
		if (hi < jmin) hi = jmin;
		if (hi > jmax) hi = jmax;
	endfunction

	// advance the model by one accepted transaction, queue the expected result
	function automatic void predict_point(joint_cmd_t cmd);
		traj_point_t t;
		longint      lo, hi, st;
		t = '{default: '0};
		case (cmd.op)
			OPC_START: begin
				clamped_bounds(lo, hi);
				st = longint'(cmd.pos);
				model_elapsed = 0;
				model_stop = 0;
				if (lo >= hi || st < lo || st > hi) begin
					model_status = ST_FAIL;
				end else begin
					model_lo = lo;
					model_hi = hi;
					model_phase0 = 64'(32'(2 * vec_angle(
						longint'(int_sqrt(64'(st - lo) << 28)),
						longint'(int_sqrt(64'(hi - st) << 28)))));
					model_status = ST_RUN;
					t = traj_eval();
				end
			end
			OPC_TICK: begin
				if (model_status == ST_RUN) begin
					t = traj_eval();
					if (model_elapsed > 64'(shadow_reg[REG_DURATION][23:0])) begin
						model_elapsed = 64'(shadow_reg[REG_DURATION][23:0]);
						if (cmd.settled) model_status = ST_OK;
					end else if (model_stop) begin
						model_status = ST_INTR;
					end
					if (model_status == ST_RUN) model_elapsed++;
				end
			end
			OPC_STOP: begin
				if (model_status == ST_RUN) model_stop = 1;
			end
			default: ;
		endcase
		t.status = model_status;
		t.ticks = model_elapsed[24:0];
		expected_points.push_back(t);
	endfunction

	// ------------------------------------------------------------------------
	// driver: one input transaction at a time from cmd_queue, random gaps
	// ------------------------------------------------------------------------
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		joint_cmd_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				predict_point('{opcode, start_position, settled});
				if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 5);
			end
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				nxt = cmd_queue.pop_front();
				opcode <= nxt.op;
				start_position <= nxt.pos;
				settled <= nxt.settled;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: back-pressure bursts on the result side, field-by-field check
	// ------------------------------------------------------------------------
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		traj_point_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					$display("%0t ERROR unexpected result: pos %h status %0d",
						$time, position_target, run_status);
					error_count++;
				end else begin
					e = expected_points.pop_front();
					if (position_target !== e.pos) begin
						$display("%0t ERROR position_target exp %h act %h",
							$time, e.pos, position_target);
						error_count++;
					end
					if (velocity !== e.vel) begin
						$display("%0t ERROR velocity exp %h act %h", $time, e.vel, velocity);
						error_count++;
					end
					if (acceleration !== e.acc) begin
						$display("%0t ERROR acceleration exp %h act %h",
							$time, e.acc, acceleration);
						error_count++;
					end
					if (run_status !== e.status) begin
						$display("%0t ERROR run_status exp %0d act %0d",
							$time, e.status, run_status);
						error_count++;
					end
					if (progress_ticks !== e.ticks) begin
						$display("%0t ERROR progress_ticks exp %0d act %0d",
							$time, e.ticks, progress_ticks);
						error_count++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 4);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	function automatic void push_cmd(logic [1:0] op, logic [31:0] pos, logic st);
		cmd_queue.push_back('{op, pos, st});
		issued++;
	endfunction

	// start position inside the clamped bounds, ends included
	function automatic logic [31:0] pick_start();
		longint lo, hi;
		clamped_bounds(lo, hi);
		if (lo >= hi) return $urandom;
		case ($urandom_range(0, 3))
			0:       return 32'(lo);
			1:       return 32'(hi);
			default: return 32'(lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1)));
		endcase
	endfunction

	// block is idle: nothing queued, nothing owed, plus the start latency
	task automatic wait_idle();
		while (cmd_queue.size() != 0 || in_valid || expected_points.size() != 0)
			@(posedge clk);
		repeat (160) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		shadow_reg[idx] = data;
	endtask

	task automatic program_run(logic [31:0] jmin, logic [31:0] jmax, logic [31:0] lo,
			logic [31:0] hi, logic [31:0] step, logic [31:0] rate, logic [23:0] dur);
		write_reg(REG_JOINT_MIN, jmin);
		write_reg(REG_JOINT_MAX, jmax);
		write_reg(REG_LOWER, lo);
		write_reg(REG_UPPER, hi);
		write_reg(REG_PHASE_STEP, step);
		write_reg(REG_ANG_RATE, rate);
		write_reg(REG_DURATION, {8'b0, dur});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int n_ticks;
		shadow_reg = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0};
		model_elapsed = 0;
		model_phase0 = 0;
		model_lo = 0;
		model_hi = 0;
		model_status = ST_IDLE;
		model_stop = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: idle tick, idle stop, unused opcode, start on empty bounds, tick after it
		push_cmd(OPC_TICK, 0, 1);
		push_cmd(OPC_STOP, 0, 0);
		push_cmd(OPC_UNUSED, 32'hFFFF_FFFF, 1);
		push_cmd(OPC_START, 0, 0);
		push_cmd(OPC_TICK, 0, 0);
		wait_idle();

		// +-1 rad, 1/256 turn per tick, ~2*pi rad/s, 4 ticks
		program_run(32'h8000_0000, 32'h7FFF_FFFF, 32'hF000_0000, 32'h1000_0000,
			32'h0100_0000, 32'h0648_7ED5, 24'd4);
		push_cmd(OPC_START, 32'hF000_0000, 0);     // at the lower bound
		repeat (3) push_cmd(OPC_TICK, 0, 0);
		push_cmd(OPC_STOP, 0, 0);
		push_cmd(OPC_TICK, 0, 1);                  // interrupted
		push_cmd(OPC_TICK, 0, 1);                  // no longer running
		push_cmd(OPC_START, 32'h1000_0000, 0);     // at the upper bound
		repeat (6) push_cmd(OPC_TICK, 0, 0);       // past the end, not settled
		push_cmd(OPC_STOP, 0, 0);                  // too late to interrupt
		push_cmd(OPC_TICK, 0, 1);                  // settled: done
		push_cmd(OPC_START, 32'h0400_0000, 0);
		push_cmd(OPC_STOP, 0, 0);
		push_cmd(OPC_START, 32'h0400_0000, 0);     // restart drops the stop
		push_cmd(OPC_TICK, 0, 0);
		push_cmd(OPC_START, 32'h1000_0001, 0);     // just above the bounds
		wait_idle();

		// joint limits crossed: bounds collapse and the start fails
		program_run(32'h1000_0000, 32'hF000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
		push_cmd(OPC_START, 0, 0);
		wait_idle();

		// full range, fastest phase and rate: saturated outputs
		program_run(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
		push_cmd(OPC_START, 32'h7FFF_FFFF, 1);
		repeat (2) push_cmd(OPC_TICK, 0, 1);
		push_cmd(OPC_START, 32'h8000_0000, 0);
		push_cmd(OPC_TICK, 0, 0);
		wait_idle();

		// random phases of well-formed runs with some noise
		while (issued < 1150) begin
			logic [31:0] jmin, jmax, lo, hi, span;
			if (issued >= 1060) calm = 1'b1;
			jmin = 32'h8000_0000;
			jmax = 32'h7FFF_FFFF;
			if ($urandom_range(0, 3) == 0) begin
				jmin = $urandom;
				jmax = $urandom;
			end
			span = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'h3FFF_FFFF;
			lo = $signed($urandom & span) >>> 1;
			hi = $signed($urandom & span) >>> 1;
			if ($urandom_range(0, 4) != 0 && $signed(lo) > $signed(hi)) {lo, hi} = {hi, lo};
			program_run(jmin, jmax, lo, hi,
				$urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 32'h0400_0000),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h1000_0000),
				$urandom_range(0, 9) == 0 ? 24'($urandom) : 24'($urandom_range(0, 20)));
			repeat ($urandom_range(1, 3)) begin
				push_cmd(OPC_START, $urandom_range(0, 9) == 0 ? $urandom : pick_start(),
					$urandom_range(0, 1));
				n_ticks = shadow_reg[REG_DURATION] + $urandom_range(0, 5);
				if (n_ticks > 30) n_ticks = $urandom_range(1, 30);
				repeat (n_ticks) begin
					case ($urandom_range(0, 19))
						0:       push_cmd(OPC_STOP, $urandom, $urandom_range(0, 1));
						1:       push_cmd(OPC_UNUSED, $urandom, $urandom_range(0, 1));
						2:       push_cmd(2'($urandom), $urandom, $urandom_range(0, 1));
						default: push_cmd(OPC_TICK, $urandom, $urandom_range(0, 3) == 0);
					endcase
				end
			end
			wait_idle();
		end

		while (cmd_queue.size() != 0 || in_valid || expected_points.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#(60_000_000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
